FILE: sv/yuv2argb_pkg.sv
// Shared types, coefficients and helpers for the YUV 4:2:0 pair to ARGB converter.
package yuv2argb_pkg;

    localparam int IDX_W   = 4;
    localparam int DIM_W   = 14;
    localparam int COEF_W  = 12;
    localparam int PROD_W  = 20;
    localparam int OFF_W   = 10;
    localparam int SUM_W   = 11;
    localparam int FRAC_BITS = 10;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    // High-definition thresholds
    localparam logic [DIM_W-1:0] HD_WIDTH  = 14'd1280;
    localparam logic [DIM_W-1:0] HD_HEIGHT = 14'd720;

    // BT.601 coefficients (Q10)
    localparam logic signed [COEF_W-1:0] SD_CR_R = 12'sd1436;
    localparam logic signed [COEF_W-1:0] SD_CB_G = 12'sd352;
    localparam logic signed [COEF_W-1:0] SD_CR_G = 12'sd731;
    localparam logic signed [COEF_W-1:0] SD_CB_B = 12'sd1815;

    // BT.709 coefficients (Q10)
    localparam logic signed [COEF_W-1:0] HD_CR_R = 12'sd1613;
    localparam logic signed [COEF_W-1:0] HD_CB_G = 12'sd192;
    localparam logic signed [COEF_W-1:0] HD_CR_G = 12'sd479;
    localparam logic signed [COEF_W-1:0] HD_CB_B = 12'sd1900;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = 20'sd512;
    localparam logic [7:0]               ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic       present;
        logic [7:0] chroma_red;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] luma_first;
    } pair_in_t;

    typedef struct packed {
        logic        second_valid;
        logic [31:0] argb_second;
        logic [31:0] argb_first;
    } pair_out_t;

    // Saturate a signed channel sum to one byte
    function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // Build one ARGB word from luma and the three chroma offsets
    function automatic logic [31:0] make_pixel(
        input logic [7:0]              y,
        input logic signed [OFF_W-1:0] r_off,
        input logic signed [OFF_W-1:0] g_off,
        input logic signed [OFF_W-1:0] b_off
    );
        logic signed [SUM_W-1:0] y_s;
        logic signed [SUM_W-1:0] r_sum;
        logic signed [SUM_W-1:0] g_sum;
        logic signed [SUM_W-1:0] b_sum;
        y_s   = $signed({3'b000, y});
        r_sum = y_s + SUM_W'(r_off);
        g_sum = y_s - SUM_W'(g_off);
        b_sum = y_s + SUM_W'(b_off);
        return {ALPHA_OPAQUE, clamp_byte(r_sum), clamp_byte(g_sum), clamp_byte(b_sum)};
    endfunction

endpackage

FILE: sv/yuv2argb_cfg.sv
// Frame size registers and the BT.709 / BT.601 standard select.
module yuv2argb_cfg
    import yuv2argb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    output logic             hd
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    assign hd = (width_reg >= HD_WIDTH) || (height_reg >= HD_HEIGHT);

endmodule

FILE: sv/yuv2argb_conv.sv
// Chroma offset products and clamped ARGB assembly for one pixel pair.
module yuv2argb_conv
    import yuv2argb_pkg::*;
(
    input  logic      hd,
    input  pair_in_t  pair_in,
    output pair_out_t pair_out
);

    logic signed [8:0]        cb_s;
    logic signed [8:0]        cr_s;
    logic signed [COEF_W-1:0] k_cr_r;
    logic signed [COEF_W-1:0] k_cb_g;
    logic signed [COEF_W-1:0] k_cr_g;
    logic signed [COEF_W-1:0] k_cb_b;
    logic signed [PROD_W-1:0] r_sum;
    logic signed [PROD_W-1:0] g_sum;
    logic signed [PROD_W-1:0] b_sum;
    logic signed [OFF_W-1:0]  r_off;
    logic signed [OFF_W-1:0]  g_off;
    logic signed [OFF_W-1:0]  b_off;

    always_comb
    begin
        cb_s = $signed({1'b0, pair_in.chroma_blue}) - 9'sd128;
        cr_s = $signed({1'b0, pair_in.chroma_red}) - 9'sd128;

        k_cr_r = hd ? HD_CR_R : SD_CR_R;
        k_cb_g = hd ? HD_CB_G : SD_CB_G;
        k_cr_g = hd ? HD_CR_G : SD_CR_G;
        k_cb_b = hd ? HD_CB_B : SD_CB_B;

        r_sum = k_cr_r * cr_s + ROUND_HALF;
        g_sum = k_cb_g * cb_s + k_cr_g * cr_s + ROUND_HALF;
        b_sum = k_cb_b * cb_s + ROUND_HALF;

        // arithmetic shift gives floor division by 1024
        r_off = OFF_W'(r_sum >>> FRAC_BITS);
        g_off = OFF_W'(g_sum >>> FRAC_BITS);
        b_off = OFF_W'(b_sum >>> FRAC_BITS);

        pair_out.argb_first   = make_pixel(pair_in.luma_first, r_off, g_off, b_off);
        pair_out.argb_second  = pair_in.present
                              ? make_pixel(pair_in.luma_second, r_off, g_off, b_off)
                              : 32'd0;
        pair_out.second_valid = pair_in.present;
    end

endmodule

FILE: sv/yuv420_pair_to_argb.sv
// Top level: YUV 4:2:0 pixel pair to two ARGB words, two-stage stream pipeline.
// An accepted input item passes through the input register, then the result register.
// Throughput: one item per cycle; the input register and the result register
// each advance whenever the stage behind them is empty or being drained.
// Reset: clears both stage valid flags and both frame size registers (BT.601).
// Configuration writes are always accepted (cfg_ready tied high).
module yuv420_pair_to_argb
    import yuv2argb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    // input pair stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // luma_first, luma_second, chroma_blue, chroma_red
    input  logic             s_axis_tuser,   // second_present

    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // argb_first, argb_second
    output logic             m_axis_tuser,   // second_valid

    // configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    logic      hd;
    pair_in_t  in_reg;
    logic      in_valid_reg;
    pair_out_t out_reg;
    logic      out_valid_reg;
    pair_out_t conv_out;
    logic      out_advance;
    logic      in_load;

    yuv2argb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hd        (hd)
    );

    // The result register can take a new item when it is empty or being drained.
    assign out_advance = !out_valid_reg || m_axis_tready;
    // The input register can take a new item when it is empty or moving forward.
    assign s_axis_tready = !in_valid_reg || out_advance;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // Input stage: hold the raw pair while the result register is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg.luma_first  <= s_axis_tdata[7:0];
            in_reg.luma_second <= s_axis_tdata[15:8];
            in_reg.chroma_blue <= s_axis_tdata[23:16];
            in_reg.chroma_red  <= s_axis_tdata[31:24];
            in_reg.present     <= s_axis_tuser;
        end
    end

    // Offsets, sums and clamps between the two registers.
    yuv2argb_conv u_conv (
        .hd       (hd),
        .pair_in  (in_reg),
        .pair_out (conv_out)
    );

    // Result stage: advance when downstream takes the item or the slot is empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            out_reg <= conv_out;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.argb_second, out_reg.argb_first};
    assign m_axis_tuser  = out_reg.second_valid;

endmodule

FILE: sv/yuv2argb_chk.sv
// Port-level checker for the pair converter, bound to the top level.
module yuv2argb_chk
    import yuv2argb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        cfg_ready
);

    // Stalled result item holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // First pixel is always opaque
    a_alpha_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:24] == ALPHA_OPAQUE)
        else $error("first pixel alpha not opaque");

    // Absent second pixel reads as zero, present one is opaque
    a_second_absent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:32] == 32'd0)
        else $error("absent second pixel not zero");

    a_second_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:56] == ALPHA_OPAQUE)
        else $error("second pixel alpha not opaque");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind yuv420_pair_to_argb yuv2argb_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_ready     (cfg_ready)
);
